// ----- src/kac_pkg.sv -----
// ---------------------------------------------------------------------------
// kac_pkg
// Shared types and constants of the keypad alarm controller: channel words,
// action codes, mode encodings and register reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package kac_pkg;

    // field widths fixed by the channel definitions
    localparam int ACTION_W    = 2;
    localparam int DIGIT_W     = 4;
    localparam int MODE_W      = 2;
    localparam int DIGITS_W    = 2;
    localparam int COUNT_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // the code register holds four digits, later digits compare against zero
    localparam int STORED_DIGITS = 4;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] CODE_RESET   = 16'd533;
    localparam logic [CFG_DATA_W-1:0] RELOAD_RESET = 16'd60000;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CODE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELOAD = 1'b1;

    // action codes of an input word
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ARM  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_KEY  = 2'd2;

    // mode encoding on the result word
    localparam logic [MODE_W-1:0] MODE_CODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_ARMED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_ALARM = 2'd2;

    // internal controller state
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_ARMED = 3'b010,
        MODE_ALARM = 3'b100
    } mode_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DIGIT_W-1:0]  key_value;
    } in_word_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                buzzer;
        logic [DIGITS_W-1:0] digits_entered;
        logic [COUNT_W-1:0]  countdown_left;
    } out_word_t;

endpackage

`default_nettype wire

// ----- src/kac_in_if.sv -----
// ---------------------------------------------------------------------------
// kac_in_if
// Input channel: valid/ready handshake carrying one event word.
// ---------------------------------------------------------------------------
`default_nettype none

interface kac_in_if
    import kac_pkg::*;
();

    logic     valid;
    logic     ready;
    in_word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);

endinterface

`default_nettype wire

// ----- src/kac_out_if.sv -----
// ---------------------------------------------------------------------------
// kac_out_if
// Output channel: valid/ready handshake carrying one status word.
// ---------------------------------------------------------------------------
`default_nettype none

interface kac_out_if
    import kac_pkg::*;
();

    logic      valid;
    logic      ready;
    out_word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);

endinterface

`default_nettype wire

// ----- src/kac_step.sv -----
// ---------------------------------------------------------------------------
// kac_step
// Controller state and configuration registers with the combinational
// next-state logic; drives the status word that the accepted event produces.
// ---------------------------------------------------------------------------
`default_nettype none

module kac_step
    import kac_pkg::*;
#(
    parameter int CODE_LENGTH    = 4,
    parameter int TICKS_PER_STEP = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   accept,
    input  wire in_word_t               in_word,
    output out_word_t                   result
);

    localparam int CNT_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int PS_W  = (TICKS_PER_STEP > 1) ? $clog2(TICKS_PER_STEP) : 1;
    localparam int BUF_D = (CODE_LENGTH > 1) ? CODE_LENGTH - 1 : 1;
    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(CODE_LENGTH - 1);
    localparam logic [PS_W-1:0]  LAST_TICK  = PS_W'(TICKS_PER_STEP - 1);

    logic [CFG_DATA_W-1:0] code_reg;
    logic [CFG_DATA_W-1:0] reload_reg;

    mode_t              mode_reg,      mode_next;
    logic [COUNT_W-1:0] countdown_reg, countdown_next;
    logic [PS_W-1:0]    prescale_reg,  prescale_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic               buzzer_reg,    buzzer_next;
    logic [DIGIT_W-1:0] entry_reg [BUF_D];

    logic [DIGIT_W-1:0] want [CODE_LENGTH];
    logic               key_store;
    logic               match;
    logic [CNT_W+1:0]   count_wide;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg   <= CODE_RESET;
            reload_reg <= RELOAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CODE:   code_reg   <= cfg_data;
                REG_RELOAD: reload_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // expected digit per position, zero past the stored four
    for (genvar g = 0; g < CODE_LENGTH; g++)
    begin : g_want
        if (g < STORED_DIGITS)
        begin : g_stored
            assign want[g] = code_reg[g*DIGIT_W +: DIGIT_W];
        end
        else
        begin : g_zero
            assign want[g] = '0;
        end
    end

    // compare held digits plus the incoming last digit
    always_comb
    begin
        match = (in_word.key_value == want[CODE_LENGTH-1]);
        for (int i = 0; i < CODE_LENGTH - 1; i++)
        begin
            if (entry_reg[i] != want[i])
            begin
                match = 1'b0;
            end
        end
    end

    // next-state logic for one event
    always_comb
    begin
        mode_next      = mode_reg;
        countdown_next = countdown_reg;
        prescale_next  = prescale_reg;
        count_next     = count_reg;
        buzzer_next    = buzzer_reg;
        key_store      = 1'b0;
        if (accept)
        begin
            unique case (in_word.action)
                ACT_TICK:
                begin
                    if (prescale_reg == LAST_TICK)
                    begin
                        prescale_next = '0;
                        if (mode_reg == MODE_ARMED && countdown_reg != '0)
                        begin
                            countdown_next = countdown_reg - 1'b1;
                            if (countdown_reg == COUNT_W'(1))
                            begin
                                mode_next   = MODE_ALARM;
                                buzzer_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        prescale_next = prescale_reg + 1'b1;
                    end
                end
                ACT_ARM:
                begin
                    if (mode_reg == MODE_IDLE)
                    begin
                        mode_next      = MODE_ARMED;
                        countdown_next = reload_reg;
                    end
                end
                ACT_KEY:
                begin
                    if (mode_reg == MODE_ARMED)
                    begin
                        if (count_reg == LAST_DIGIT)
                        begin
                            count_next = '0;
                            if (match)
                            begin
                                mode_next      = MODE_IDLE;
                                countdown_next = reload_reg;
                                buzzer_next    = 1'b0;
                            end
                        end
                        else
                        begin
                            key_store  = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            countdown_reg <= RELOAD_RESET;
            prescale_reg  <= '0;
            count_reg     <= '0;
            buzzer_reg    <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            countdown_reg <= countdown_next;
            prescale_reg  <= prescale_next;
            count_reg     <= count_next;
            buzzer_reg    <= buzzer_next;
        end
    end

    // entry digits, written in order
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CODE_LENGTH - 1; i++)
        begin
            if (key_store && count_reg == CNT_W'(i))
            begin
                entry_reg[i] <= in_word.key_value;
            end
        end
    end

    // status word after this event
    assign count_wide = {2'b00, count_next};

    always_comb
    begin
        unique case (mode_next)
            MODE_IDLE:  result.mode = MODE_CODE_IDLE;
            MODE_ARMED: result.mode = MODE_CODE_ARMED;
            MODE_ALARM: result.mode = MODE_CODE_ALARM;
            default:    result.mode = MODE_CODE_IDLE;
        endcase
        result.buzzer         = buzzer_next;
        result.digits_entered = count_wide[DIGITS_W-1:0];
        result.countdown_left = countdown_next;
    end

endmodule

`default_nettype wire

// ----- src/kac_out_buf.sv -----
// ---------------------------------------------------------------------------
// kac_out_buf
// Result register with a skid entry: holds up to two status words so the
// event side can keep pushing while the consumer stalls, until both are full.
// ---------------------------------------------------------------------------
`default_nettype none

module kac_out_buf
    import kac_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_word_t push_word,
    output logic           can_push,
    kac_out_if.source      out_ch
);

    out_word_t head_reg;
    out_word_t skid_reg;
    logic      head_valid_reg;
    logic      skid_valid_reg;
    logic      pop;

    assign pop          = head_valid_reg && out_ch.ready;
    assign can_push     = !skid_valid_reg;
    assign out_ch.valid = head_valid_reg;
    assign out_ch.word  = head_reg;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                head_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                head_valid_reg <= 1'b1;
            end
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            head_reg <= skid_valid_reg ? skid_reg : push_word;
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_reg <= push_word;
            end
            else
            begin
                head_reg <= push_word;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/keypad_alarm_controller.sv -----
// ---------------------------------------------------------------------------
// keypad_alarm_controller
// Three-mode security alarm (idle, armed, alarm) with keypad code entry.
// ---------------------------------------------------------------------------
// One event word is accepted per clock cycle while the output buffer has
// room; each produces exactly one status word, which is queued in the
// output buffer behind any words still waiting there. All state updates and
// the code compare are combinational, between the state registers and a
// two-word output buffer, so the input only stalls when the consumer has
// held off long enough to fill both output entries. There is no clearing
// pass after reset; the block is ready at once. Configuration writes (code,
// countdown reload) take effect at the clock edge of the write.
`default_nettype none

module keypad_alarm_controller
    import kac_pkg::*;
#(
    parameter int CODE_LENGTH    = 4,
    parameter int TICKS_PER_STEP = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    kac_in_if.sink                      in_ch,
    kac_out_if.source                   out_ch
);

    logic      accept;
    logic      can_push;
    out_word_t result;

    // event handshake
    assign in_ch.ready = can_push;
    assign accept      = in_ch.valid && can_push;

    // state update
    kac_step #(
        .CODE_LENGTH    (CODE_LENGTH),
        .TICKS_PER_STEP (TICKS_PER_STEP)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_word   (in_ch.word),
        .result    (result)
    );

    // result register and skid
    kac_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (result),
        .can_push  (can_push),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
